>>> rtl/ptws_pkg.sv
// Shared types and constants for the prefix tree word store.
// Holds the command codes, controller state encoding and the
// command/status structs between controller and datapath. No dependencies.
package ptws_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned LetterW   = 5;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned InUserW   = 3;
  localparam int unsigned OutDataW  = 8;
  localparam int unsigned OutUserW  = 2;

  // Request commands; any other code behaves as prefix search.
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_SEARCH = 2'd1;

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_LOOK   = 6'b000100,
    ST_ALLOC  = 6'b001000,
    ST_END_RD = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic init;
    logic accept;
    logic look;
    logic alloc;
    logic rd_end;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk;
    logic in_last;
    logic last;
    logic link_hit;
    logic insert;
    logic pool_free;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/ptws_ctrl.sv
// Controller state machine for the prefix tree word store.
// Sequences lookup, node allocation and end-mark update; uses ptws_pkg.
module ptws_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  ptws_pkg::dp_sts_t    sts_i,
  output ptws_pkg::ctrl_cmd_t  cmd_o
);
  import ptws_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        // clear the root row once after reset
        cmd_o.init = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.walk) begin
            state_d = ST_LOOK;
          end else if (sts_i.in_last) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
        if (sts_i.link_hit) begin
          state_d = sts_i.last ? ST_END_RD : ST_IDLE;
        end else if (sts_i.insert && sts_i.pool_free) begin
          state_d = ST_ALLOC;
        end else begin
          state_d = sts_i.last ? ST_FINISH : ST_IDLE;
        end
      end
      ST_ALLOC: begin
        cmd_o.alloc = 1'b1;
        state_d     = sts_i.last ? ST_END_RD : ST_IDLE;
      end
      ST_END_RD: begin
        cmd_o.rd_end = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the result register can take the answer
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  a_cmd_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

  a_walk_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && sts_i.walk) |=> cmd_o.look)
    else $error("walking request not followed by lookup");

  a_alloc_after_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.alloc |-> $past(cmd_o.look))
    else $error("node allocated without preceding lookup");

  a_rd_end_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_end |=> (state_q == ST_FINISH))
    else $error("end-mark read not followed by finish");

endmodule

>>> rtl/ptws_dp.sv
// Datapath for the prefix tree word store: node row memory, walk registers,
// allocation counter and result register. Uses ptws_pkg.
module ptws_dp #(
  parameter int unsigned NODE_COUNT    = 1024,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ptws_pkg::ctrl_cmd_t             cmd_i,
  output ptws_pkg::dp_sts_t               sts_o,
  input  logic [ptws_pkg::CmdW-1:0]       in_cmd_i,
  input  logic [ptws_pkg::LetterW-1:0]    in_letter_i,
  input  logic                            in_has_letter_i,
  input  logic                            in_first_i,
  input  logic                            in_last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ptws_pkg::CmdW-1:0]       out_op_done_o,
  output logic                            out_hit_o,
  output logic                            out_pool_full_o
);
  import ptws_pkg::*;

  localparam int unsigned NW         = $clog2(NODE_COUNT);
  localparam int unsigned UW         = $clog2(NODE_COUNT + 1);
  localparam int unsigned LW         = $clog2(ALPHABET_SIZE);
  localparam int unsigned RW         = ALPHABET_SIZE * NW + 1;
  localparam int unsigned EndBit     = RW - 1;
  localparam int unsigned LetterExtW = 9;

  // One row per node: child links, end mark in the top bit
  logic [RW-1:0]   mem_q [NODE_COUNT];
  logic [RW-1:0]   row_q;

  logic [NW-1:0]   cur_q, cur_d;
  logic [UW-1:0]   used_q, used_d;
  logic            miss_q, miss_d;
  logic            full_q, full_d;
  logic [CmdW-1:0] cmd_q;
  logic [LW-1:0]   lane_q;
  logic            last_q;

  logic            out_valid_q;
  logic [CmdW-1:0] out_cmd_q;
  logic            out_hit_q;
  logic            out_full_q;

  logic [LetterExtW-1:0] letter_ext;
  logic            in_range;
  logic [NW-1:0]   eff_cur;
  logic            eff_miss;
  logic            eff_full;
  logic            walk;
  logic [NW-1:0]   link;
  logic            link_hit;
  logic            pool_free;
  logic [NW-1:0]   used_idx;
  logic            ok;
  logic            is_insert;
  logic            res_hit;
  logic            res_full;
  logic            out_free;

  logic            wr_en;
  logic [NW-1:0]   wr_addr;
  logic [RW-1:0]   wr_data;
  logic            rd_en;
  logic [NW-1:0]   rd_addr;

  assign letter_ext = {{(LetterExtW - LetterW){1'b0}}, in_letter_i};
  assign in_range   = letter_ext < LetterExtW'(ALPHABET_SIZE);
  assign eff_cur    = in_first_i ? '0 : cur_q;
  assign eff_miss   = in_first_i ? 1'b0 : miss_q;
  assign eff_full   = in_first_i ? 1'b0 : full_q;
  assign walk       = in_has_letter_i & in_range & ~eff_miss & ~eff_full;

  assign link      = row_q[lane_q * NW +: NW];
  assign link_hit  = (link != '0);
  assign pool_free = (used_q < UW'(NODE_COUNT));
  assign used_idx  = used_q[NW-1:0];
  assign ok        = ~miss_q & ~full_q;
  assign is_insert = (cmd_q == CMD_INSERT);
  assign out_free  = ~out_valid_q | out_ready_i;

  always_comb begin
    case (cmd_q)
      CMD_INSERT: res_hit = ok;
      CMD_SEARCH: res_hit = ok & row_q[EndBit];
      default:    res_hit = ok;
    endcase
  end
  assign res_full = is_insert & full_q;

  always_comb begin
    sts_o.walk      = walk;
    sts_o.in_last   = in_last_i;
    sts_o.last      = last_q;
    sts_o.link_hit  = link_hit;
    sts_o.insert    = is_insert;
    sts_o.pool_free = pool_free;
    sts_o.out_free  = out_free;
  end

  // Single write port: root clear, parent link, fresh row, or end mark
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_q;
    wr_data = row_q;
    if (cmd_i.init) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = '0;
    end else if (cmd_i.look && !link_hit && is_insert && pool_free) begin
      wr_en                        = 1'b1;
      wr_data[lane_q * NW +: NW]   = used_idx;
    end else if (cmd_i.alloc) begin
      wr_en   = 1'b1;
      wr_addr = used_idx;
      wr_data = '0;
    end else if (cmd_i.finish && is_insert && ok) begin
      wr_en           = 1'b1;
      wr_data[EndBit] = 1'b1;
    end
  end

  assign rd_en   = cmd_i.accept | cmd_i.rd_end;
  assign rd_addr = cmd_i.rd_end ? cur_q : eff_cur;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      row_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    cur_d  = cur_q;
    used_d = used_q;
    miss_d = miss_q;
    full_d = full_q;
    if (cmd_i.accept) begin
      cur_d  = eff_cur;
      miss_d = eff_miss | (in_has_letter_i & ~in_range & ~eff_full);
      full_d = eff_full;
    end else if (cmd_i.look) begin
      if (link_hit) begin
        cur_d = link;
      end else if (!is_insert) begin
        miss_d = 1'b1;
      end else if (!pool_free) begin
        full_d = 1'b1;
      end
    end else if (cmd_i.alloc) begin
      cur_d  = used_idx;
      used_d = used_q + UW'(1);
    end else if (cmd_i.finish) begin
      // return to the root for the next word
      cur_d  = '0;
      miss_d = 1'b0;
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      used_q      <= UW'(1);
      miss_q      <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      used_q <= used_d;
      miss_q <= miss_d;
      full_q <= full_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q  <= in_cmd_i;
      lane_q <= letter_ext[LW-1:0];
      last_q <= in_last_i;
    end
    if (cmd_i.finish) begin
      out_cmd_q  <= cmd_q;
      out_hit_q  <= res_hit;
      out_full_q <= res_full;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_op_done_o   = out_cmd_q;
  assign out_hit_o       = out_hit_q;
  assign out_pool_full_o = out_full_q;

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != '0) && (used_q <= UW'(NODE_COUNT)))
    else $error("node count out of range");

  a_cur_allocated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    UW'(cur_q) < used_q)
    else $error("walk sits on an unallocated node");

  a_alloc_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc |=> (used_q == $past(used_q) + UW'(1)))
    else $error("allocation did not advance node count");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_full_q) |-> ((out_cmd_q == CMD_INSERT) && !out_hit_q))
    else $error("pool-full result on a non-insert or with hit");

endmodule

>>> rtl/prefix_tree_word_store.sv
// Prefix tree word store, top level. A walking letter is looked up in the node
// row memory between accept and the next ready, and a node is created when an
// insert finds no link and the pool has room; an item that does not walk (no
// letter, out of range, after a miss) needs no lookup. A last item then gives
// the result, after an end-mark read if the walk reached a node, and waits while
// the result register stays full. After reset the root row is cleared with
// s_axis_tready_o low; control state resets asynchronously.
module prefix_tree_word_store #(
  parameter int unsigned NODE_COUNT    = 1024,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [4:0] letter, [5] first_item, [7:6] zero
  input  logic [ptws_pkg::InDataW-1:0]      s_axis_tdata_i,
  // [1:0] cmd, [2] has_letter
  input  logic [ptws_pkg::InUserW-1:0]      s_axis_tuser_i,
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [0] hit, [1] pool_full, [7:2] zero
  output logic [ptws_pkg::OutDataW-1:0]     m_axis_tdata_o,
  // [1:0] op_done
  output logic [ptws_pkg::OutUserW-1:0]     m_axis_tuser_o
);
  import ptws_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;
  logic      res_hit;
  logic      res_pool_full;

  ptws_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (dp_sts),
    .cmd_o     (ctrl_cmd)
  );

  ptws_dp #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .sts_o           (dp_sts),
    .in_cmd_i        (s_axis_tuser_i[CmdW-1:0]),
    .in_letter_i     (s_axis_tdata_i[LetterW-1:0]),
    .in_has_letter_i (s_axis_tuser_i[CmdW]),
    .in_first_i      (s_axis_tdata_i[LetterW]),
    .in_last_i       (s_axis_tlast_i),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_op_done_o   (m_axis_tuser_o),
    .out_hit_o       (res_hit),
    .out_pool_full_o (res_pool_full)
  );

  assign m_axis_tdata_o = {{(OutDataW - 2){1'b0}}, res_pool_full, res_hit};

endmodule
